[rtl/aass_pkg.sv]
// ============================================================================
// aass_pkg: shared definitions for the ADC average, scale and smooth block
// Field widths, register indexes, reset values and arithmetic constants.
// ============================================================================
`default_nettype none

package aass_pkg;

    // Field widths of the sample and result channels.
    localparam int CHANNEL_W = 2;
    localparam int SAMPLE_W  = 12;
    localparam int VALUE_W   = 32;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int AVG_COUNT_W = 9;
    localparam int SMOOTH_W    = 17;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_AVG_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUT_MIN   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUT_MAX   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SMOOTHING = 3'd4;

    // Register reset values.
    localparam logic [AVG_COUNT_W-1:0] AVG_COUNT_RST = 9'd1;
    localparam logic [VALUE_W-1:0]     OUT_MIN_RST   = 32'd0;
    localparam logic [VALUE_W-1:0]     OUT_MAX_RST   = 32'd6553600;
    localparam logic [VALUE_W-1:0]     OFFSET_RST    = 32'd0;
    localparam logic [SMOOTH_W-1:0]    SMOOTHING_RST = 17'd0;

    // Per-channel state widths.
    localparam int COUNT_W = 9;
    localparam int SUM_W   = 20;

    // Arithmetic constants: ADC span of 4096 codes is a shift by 12,
    // and one in Q1.16 is 65536.
    localparam int                     SPAN_SHIFT = 12;
    localparam int                     FRAC_BITS  = 16;
    localparam logic [SMOOTH_W-1:0]    ONE_Q16    = 17'h10000;
    localparam logic [AVG_COUNT_W-1:0] AVG_MAX    = 9'd256;

    // Default channel count.
    localparam int CHANNELS_DEF = 4;

endpackage : aass_pkg

`default_nettype wire

[rtl/aass_if.sv]
// ============================================================================
// aass_if: valid/ready channels of the ADC average, scale and smooth block
// One interface for incoming samples and one for filtered results.
// ============================================================================
`default_nettype none

interface aass_in_if;
    import aass_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CHANNEL_W-1:0] channel;
    logic [SAMPLE_W-1:0]  sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface : aass_in_if

interface aass_out_if;
    import aass_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CHANNEL_W-1:0]       out_channel;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output out_channel, output value, input ready);
    modport sink   (input valid, input out_channel, input value, output ready);
endinterface : aass_out_if

`default_nettype wire

[rtl/adc_average_scale_smooth_core.sv]
// ============================================================================
// adc_average_scale_smooth_core: per-channel oversampling average, linear
// scaling and exponential smoothing of 12-bit ADC samples
//
// Usage: samples arrive as requests on the "samples" channel, each tagged
// with a channel number. The first sample of a channel after reset seeds its
// previous value and gives no result. Later samples are summed; once
// avg_count of them are in, the average is scaled onto out_min..out_max,
// offset is added, the value is blended with the previous one and sent as a
// request on the "results" channel. Samples for channels at or above
// CHANNELS are dropped.
// Throughput: one sample is worked on at a time. A sample that only adds
// to a running sum passes through S_IDLE and S_READ; a seed also passes
// through S_MUL, S_DINIT, S_DIV, S_SCALE and S_FINISH, and a sample that
// closes an average adds S_BLEND before S_FINISH. Most of this is the
// divider: 3 quotient bits per cycle over a 42-bit dividend.
// Per-channel state lives in one synchronous memory with registered reads;
// the seeded flags are flip-flops cleared at reset, so no clearing pass runs.
// Reset restores the register defaults. When the receiver stalls, the result
// waits in the output register; the next sample is still taken, and its own
// result waits until the output register is free.
// The user must write configuration only while idle; it is not enforced.
// ============================================================================
`default_nettype none

module adc_average_scale_smooth_core #(
    parameter int CHANNELS = aass_pkg::CHANNELS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    aass_in_if.sink                               samples,
    aass_out_if.source                            results,
    input  wire logic                             cfg_we,
    input  wire logic [aass_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [aass_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import aass_pkg::*;

    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MEM_W    = COUNT_W + SUM_W + VALUE_W;
    localparam int PROD_W   = (SUM_W + 1) + (VALUE_W + 1);
    localparam int DIV_W    = PROD_W - SPAN_SHIFT;
    localparam int DIV_BITS = 3;
    localparam int DIV_ITER = DIV_W / DIV_BITS;
    localparam int CNT_W    = $clog2(DIV_ITER);
    localparam int REM_W    = AVG_COUNT_W;
    localparam int TOT_W    = DIV_W + 2;
    localparam int BPROD_W  = (SMOOTH_W + 1) + (VALUE_W + 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_READ   = 8'b0000_0010,
        S_MUL    = 8'b0000_0100,
        S_DINIT  = 8'b0000_1000,
        S_DIV    = 8'b0001_0000,
        S_SCALE  = 8'b0010_0000,
        S_BLEND  = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } state_t;

    // Control state.
    state_t                  state_reg, state_next;
    logic [CHANNELS-1:0]     seeded_reg;
    logic                    out_valid_reg;

    // Configuration registers.
    logic [AVG_COUNT_W-1:0]  avg_count_reg;
    logic [VALUE_W-1:0]      out_min_reg;
    logic [VALUE_W-1:0]      out_max_reg;
    logic [VALUE_W-1:0]      offset_reg;
    logic [SMOOTH_W-1:0]     smoothing_reg;

    // Per-channel memory: {count, sum, previous value}.
    logic [MEM_W-1:0]        mem [CHANNELS];
    logic [MEM_W-1:0]        rd_data_reg;
    logic                    mem_we;
    logic [CH_W-1:0]         mem_wa;
    logic [MEM_W-1:0]        mem_wd;

    // Datapath registers.
    logic [CH_W-1:0]            ch_reg;
    logic [SAMPLE_W-1:0]        sample_reg;
    logic [SUM_W-1:0]           sum_op_reg;
    logic [AVG_COUNT_W-1:0]     n_op_reg;
    logic [VALUE_W-1:0]         prev_reg;
    logic                       seed_mode_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [DIV_W-1:0]           div_quo_reg;
    logic [REM_W-1:0]           div_rem_reg;
    logic                       div_neg_reg;
    logic [CNT_W-1:0]           div_cnt_reg;
    logic [VALUE_W-1:0]         cur_reg;
    logic signed [BPROD_W-1:0]  bprod_reg;
    logic [CHANNEL_W-1:0]       out_channel_reg;
    logic [VALUE_W-1:0]         value_reg;

    // Combinational signals.
    logic                    in_fire;
    logic                    ch_ok;
    logic [COUNT_W-1:0]      rd_count;
    logic [SUM_W-1:0]        rd_sum;
    logic [VALUE_W-1:0]      rd_prev;
    logic [SUM_W-1:0]        sum_new;
    logic [COUNT_W-1:0]      count_new;
    logic [AVG_COUNT_W-1:0]  n_eff;
    logic                    is_seeded;
    logic                    still_summing;
    logic signed [VALUE_W:0] span;
    logic signed [DIV_W-1:0] div_floor;
    logic [DIV_W-1:0]        div_mag;
    logic [DIV_W-1:0]        step_quo;
    logic [REM_W-1:0]        step_rem;
    logic [REM_W:0]          step_try;
    logic [DIV_W-1:0]        q_mag;
    logic signed [DIV_W-1:0] q_signed;
    logic signed [TOT_W-1:0] total;
    logic [VALUE_W-1:0]      scaled;
    logic [SMOOTH_W-1:0]     s_eff;
    logic signed [VALUE_W:0] diff;
    logic signed [BPROD_W-FRAC_BITS-1:0] bshift;
    logic signed [BPROD_W-FRAC_BITS-1:0] bsum;
    logic [VALUE_W-1:0]      final_value;
    logic                    finish_go;

    // Input handshake: one sample at a time.
    assign samples.ready = (state_reg == S_IDLE);
    assign in_fire       = samples.valid && samples.ready;
    assign ch_ok         = (6'(samples.channel) < 6'(CHANNELS));

    // Output channel.
    assign results.valid       = out_valid_reg;
    assign results.out_channel = out_channel_reg;
    assign results.value       = value_reg;

    // Memory word fields and the running-sum update.
    assign rd_count      = rd_data_reg[MEM_W-1 -: COUNT_W];
    assign rd_sum        = rd_data_reg[VALUE_W +: SUM_W];
    assign rd_prev       = rd_data_reg[VALUE_W-1:0];
    assign sum_new       = rd_sum + SUM_W'(sample_reg);
    assign count_new     = rd_count + COUNT_W'(1);
    assign is_seeded     = seeded_reg[ch_reg];
    assign still_summing = is_seeded && (count_new < n_eff);

    // Effective averaging count, held within 1..256.
    always_comb
    begin
        if (avg_count_reg == '0)
        begin
            n_eff = AVG_COUNT_W'(1);
        end
        else if (avg_count_reg > AVG_MAX)
        begin
            n_eff = AVG_MAX;
        end
        else
        begin
            n_eff = avg_count_reg;
        end
    end

    // Scale span and the floor of the product over 4096.
    assign span      = $signed({out_max_reg[VALUE_W-1], out_max_reg})
                     - $signed({out_min_reg[VALUE_W-1], out_min_reg});
    assign div_floor = prod_reg[PROD_W-1:SPAN_SHIFT];
    assign div_mag   = div_floor[DIV_W-1] ? DIV_W'(-div_floor) : DIV_W'(div_floor);

    // Restoring divider step: three quotient bits per cycle.
    always_comb
    begin
        step_quo = div_quo_reg;
        step_rem = div_rem_reg;
        step_try = '0;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            step_try = {step_rem, step_quo[DIV_W-1]};
            step_quo = {step_quo[DIV_W-2:0], 1'b0};
            if (step_try >= {1'b0, n_op_reg})
            begin
                step_try    = step_try - {1'b0, n_op_reg};
                step_quo[0] = 1'b1;
            end
            step_rem = step_try[REM_W-1:0];
        end
    end

    // Floor quotient with sign, plus minimum and offset, then saturation.
    assign q_mag    = div_quo_reg + DIV_W'(div_neg_reg && (div_rem_reg != '0));
    assign q_signed = div_neg_reg ? -$signed(q_mag) : $signed(q_mag);
    assign total    = $signed({{(TOT_W-VALUE_W){out_min_reg[VALUE_W-1]}}, out_min_reg})
                    + $signed({{(TOT_W-DIV_W){q_signed[DIV_W-1]}}, q_signed})
                    + $signed({{(TOT_W-VALUE_W){offset_reg[VALUE_W-1]}}, offset_reg});

    always_comb
    begin
        if (total > $signed(TOT_W'({1'b0, {(VALUE_W-1){1'b1}}})))
        begin
            scaled = {1'b0, {(VALUE_W-1){1'b1}}};
        end
        else if (total < -$signed(TOT_W'({1'b1, {(VALUE_W-1){1'b0}}})))
        begin
            scaled = {1'b1, {(VALUE_W-1){1'b0}}};
        end
        else
        begin
            scaled = total[VALUE_W-1:0];
        end
    end

    // Blend: cur + floor(s * (prev - cur) / 65536).
    assign s_eff       = (smoothing_reg > ONE_Q16) ? ONE_Q16 : smoothing_reg;
    assign diff        = $signed({prev_reg[VALUE_W-1], prev_reg})
                       - $signed({cur_reg[VALUE_W-1], cur_reg});
    assign bshift      = bprod_reg[BPROD_W-1:FRAC_BITS];
    assign bsum        = bshift + $signed({{(BPROD_W-FRAC_BITS-VALUE_W){cur_reg[VALUE_W-1]}},
                                           cur_reg});
    assign final_value = seed_mode_reg ? cur_reg : bsum[VALUE_W-1:0];
    assign finish_go   = seed_mode_reg || !out_valid_reg || results.ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && ch_ok)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = still_summing ? S_IDLE : S_MUL;
            end
            S_MUL:
            begin
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                state_next = seed_mode_reg ? S_FINISH : S_BLEND;
            end
            S_BLEND:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (finish_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory write port: running-sum update or final write-back.
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = ch_reg;
        mem_wd = {count_new, sum_new, rd_prev};
        if (state_reg == S_READ && still_summing)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == S_FINISH && finish_go)
        begin
            mem_we = 1'b1;
            mem_wd = {{COUNT_W{1'b0}}, {SUM_W{1'b0}}, final_value};
        end
    end

    // Per-channel state memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (in_fire)
        begin
            rd_data_reg <= mem[CH_W'(samples.channel)];
        end
    end

    // Control registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seeded_reg    <= '0;
            out_valid_reg <= 1'b0;
            avg_count_reg <= AVG_COUNT_RST;
            out_min_reg   <= OUT_MIN_RST;
            out_max_reg   <= OUT_MAX_RST;
            offset_reg    <= OFFSET_RST;
            smoothing_reg <= SMOOTHING_RST;
        end
        else
        begin
            state_reg <= state_next;

            if (out_valid_reg && results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_FINISH && finish_go)
            begin
                seeded_reg[ch_reg] <= 1'b1;
                if (!seed_mode_reg)
                begin
                    out_valid_reg <= 1'b1;
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_AVG_COUNT: avg_count_reg <= cfg_data[AVG_COUNT_W-1:0];
                    CFG_OUT_MIN:   out_min_reg   <= cfg_data[VALUE_W-1:0];
                    CFG_OUT_MAX:   out_max_reg   <= cfg_data[VALUE_W-1:0];
                    CFG_OFFSET:    offset_reg    <= cfg_data[VALUE_W-1:0];
                    CFG_SMOOTHING: smoothing_reg <= cfg_data[SMOOTH_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    ch_reg     <= CH_W'(samples.channel);
                    sample_reg <= samples.sample;
                end
            end
            S_READ:
            begin
                sum_op_reg    <= is_seeded ? sum_new : SUM_W'(sample_reg);
                n_op_reg      <= is_seeded ? n_eff : AVG_COUNT_W'(1);
                prev_reg      <= rd_prev;
                seed_mode_reg <= !is_seeded;
            end
            S_MUL:
            begin
                prod_reg <= $signed({1'b0, sum_op_reg}) * span;
            end
            S_DINIT:
            begin
                div_quo_reg <= div_mag;
                div_rem_reg <= '0;
                div_neg_reg <= div_floor[DIV_W-1];
                div_cnt_reg <= CNT_W'(DIV_ITER - 1);
            end
            S_DIV:
            begin
                div_quo_reg <= step_quo;
                div_rem_reg <= step_rem;
                div_cnt_reg <= div_cnt_reg - CNT_W'(1);
            end
            S_SCALE:
            begin
                cur_reg <= scaled;
            end
            S_BLEND:
            begin
                bprod_reg <= $signed({1'b0, s_eff}) * diff;
            end
            S_FINISH:
            begin
                if (finish_go && !seed_mode_reg)
                begin
                    out_channel_reg <= CHANNEL_W'(ch_reg);
                    value_reg       <= final_value;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule : adc_average_scale_smooth_core

`default_nettype wire
